[rtl/assert_macros.svh]
// Assertion helper macros shared by the RTL modules.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/mpf_pkg.sv]
// Package for the multicast prepush filter table: field widths, codes,
// parameter defaults and the controller/datapath link types.
`default_nettype none

package mpf_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned AddrW  = 48;
  localparam int unsigned MaskW  = 16;
  localparam int unsigned MachW  = 4;
  localparam int unsigned PortW  = 3;
  localparam int unsigned VcW    = 4;
  localparam int unsigned StatW  = 3;

  localparam int unsigned DefEntries   = 16;
  localparam int unsigned DefMaskSlots = 4;
  localparam int unsigned DefNodes     = 16;
  localparam int unsigned DefCountBits = 8;

  localparam logic [CmdW-1:0] CMD_REG   = 2'd0;
  localparam logic [CmdW-1:0] CMD_QUERY = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLEAR = 2'd2;

  localparam logic [StatW-1:0] ST_OK         = 3'd0;
  localparam logic [StatW-1:0] ST_NO_ENTRY   = 3'd1;
  localparam logic [StatW-1:0] ST_NO_MASK    = 3'd2;
  localparam logic [StatW-1:0] ST_TABLE_FULL = 3'd3;
  localparam logic [StatW-1:0] ST_SLOT_FULL  = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch item, start lookup and row read
    logic exec;    // apply update, load result register
  } mpf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // result register can take a new item
  } mpf_stat_t;

  function automatic logic [MaskW-1:0] node_bits(input int unsigned nodes);
    logic [MaskW-1:0] m;
    m = '0;
    for (int i = 0; i < MaskW; i++) begin
      if (i < nodes) m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/mpf_if.sv]
// Valid/ready channel interfaces for request and result items.
// Depends on mpf_pkg for field widths.
`default_nettype none

interface mpf_in_if
  import mpf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [AddrW-1:0] line_address;
  logic [MaskW-1:0] dest_mask;
  logic [MachW-1:0] machine;
  logic [PortW-1:0] in_port;
  logic [VcW-1:0]   in_vc;

  modport source (output valid, command, line_address, dest_mask, machine, in_port, in_vc,
                  input ready);
  modport sink   (input valid, command, line_address, dest_mask, machine, in_port, in_vc,
                  output ready);
endinterface

interface mpf_out_if
  import mpf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             found;
  logic             drop;
  logic [PortW-1:0] port_out;
  logic [VcW-1:0]   vc_out;
  logic [StatW-1:0] status;

  modport source (output valid, found, drop, port_out, vc_out, status, input ready);
  modport sink   (input valid, found, drop, port_out, vc_out, status, output ready);
endinterface

`default_nettype wire

[rtl/mpf_ctrl.sv]
// Controller: two-state sequencer, accept then execute.
// Depends on mpf_pkg.
`default_nettype none
`include "assert_macros.svh"

module mpf_ctrl
  import mpf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire mpf_stat_t stat_i,
  output mpf_cmd_t       cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign cmd_o.accept = in_ready_o && in_valid_i;
  assign cmd_o.exec   = (state_q == ST_EXEC) && stat_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (cmd_o.accept) state_d = ST_EXEC;
      ST_EXEC: if (stat_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_CLK(a_accept_to_exec, cmd_o.accept |=> state_q == ST_EXEC, "accept not followed by exec")
  `ASSERT_CLK(a_exec_holds, (state_q == ST_EXEC && !stat_i.out_free) |=> state_q == ST_EXEC,
              "exec left while result register busy")

endmodule

`default_nettype wire

[rtl/mpf_dpath.sv]
// Datapath: address tags, entry row memory, update logic, result register.
// Depends on mpf_pkg and the channel interfaces.
`default_nettype none
`include "assert_macros.svh"

module mpf_dpath
  import mpf_pkg::*;
#(
  parameter int unsigned ENTRIES    = DefEntries,
  parameter int unsigned MASK_SLOTS = DefMaskSlots,
  parameter int unsigned NODES      = DefNodes,
  parameter int unsigned COUNT_BITS = DefCountBits
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mpf_cmd_t cmd_i,
  input  wire logic     ready_i,
  output mpf_stat_t     stat_o,
  mpf_in_if.sink        in_i,
  mpf_out_if.source     out_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned SlW  = (MASK_SLOTS > 1) ? $clog2(MASK_SLOTS) : 1;
  localparam logic [MaskW-1:0] NodeMask = node_bits(NODES);

  typedef struct packed {
    logic [PortW-1:0]                      port;
    logic [VcW-1:0]                        vc;
    logic [MaskW-1:0]                      dest;
    logic [MASK_SLOTS-1:0][MaskW-1:0]      smask;
    logic [MASK_SLOTS-1:0][COUNT_BITS-1:0] scnt;
  } row_t;

  // tags and valid bits, compared in parallel
  logic [ENTRIES-1:0]   valid_q;
  logic [AddrW-1:0]     tag_q [ENTRIES];
  row_t                 row_mem [ENTRIES];
  row_t                 rd_q;

  // lookup on the incoming item
  logic [ENTRIES-1:0] hit;
  logic [IdxW-1:0]    hidx, fidx;
  logic               any_hit, any_free;

  always_comb begin
    hidx     = '0;
    fidx     = '0;
    any_hit  = 1'b0;
    any_free = 1'b0;
    for (int e = ENTRIES - 1; e >= 0; e--) begin
      hit[e] = valid_q[e] && (tag_q[e] == in_i.line_address);
      if (hit[e]) begin
        hidx    = IdxW'(e);
        any_hit = 1'b1;
      end
      if (!valid_q[e]) begin
        fidx     = IdxW'(e);
        any_free = 1'b1;
      end
    end
  end

  // latched item
  logic [CmdW-1:0]  cmd_q;
  logic [AddrW-1:0] addr_q;
  logic [MaskW-1:0] mask_q;
  logic [MachW-1:0] mach_q;
  logic [PortW-1:0] port_q;
  logic [VcW-1:0]   vc_q;
  logic             hit_q, fok_q;
  logic [IdxW-1:0]  hidx_q, fidx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q  <= in_i.command;
      addr_q <= in_i.line_address;
      mask_q <= in_i.dest_mask & NodeMask;
      mach_q <= in_i.machine;
      port_q <= in_i.in_port;
      vc_q   <= in_i.in_vc;
      hidx_q <= hidx;
      fidx_q <= fidx;
      rd_q   <= row_mem[hidx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      fok_q <= 1'b0;
    end else if (cmd_i.accept) begin
      hit_q <= any_hit;
      fok_q <= any_free;
    end
  end

  // slot scan on the stored row
  logic [MASK_SLOTS-1:0] live;
  logic [SlW-1:0]        midx, sidx;
  logic                  mfound, sfree;
  logic [MaskW-1:0]      others;

  always_comb begin
    midx   = '0;
    sidx   = '0;
    mfound = 1'b0;
    sfree  = 1'b0;
    for (int s = MASK_SLOTS - 1; s >= 0; s--) begin
      live[s] = (rd_q.scnt[s] != '0);
      if (live[s] && rd_q.smask[s] == mask_q) begin
        midx   = SlW'(s);
        mfound = 1'b1;
      end
      if (!live[s]) begin
        sidx  = SlW'(s);
        sfree = 1'b1;
      end
    end
    others = '0;
    for (int s = 0; s < MASK_SLOTS; s++) begin
      if (live[s] && SlW'(s) != midx) others = others | rd_q.smask[s];
    end
  end

  // update and result
  row_t             new_row;
  logic             wr_en, set_valid, clr_valid;
  logic [IdxW-1:0]  wr_idx;
  logic [StatW-1:0] status;
  logic             drop;
  logic [COUNT_BITS-1:0] cnt_dec;

  always_comb begin
    new_row   = rd_q;
    wr_en     = 1'b0;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    wr_idx    = hit_q ? hidx_q : fidx_q;
    status    = ST_OK;
    drop      = 1'b0;
    cnt_dec   = rd_q.scnt[midx] - COUNT_BITS'(1);
    case (cmd_q)
      CMD_REG: begin
        if (!hit_q) begin
          if (!fok_q) begin
            status = ST_TABLE_FULL;
          end else begin
            new_row.port     = port_q;
            new_row.vc       = vc_q;
            new_row.dest     = mask_q;
            new_row.scnt     = '0;
            new_row.smask[0] = mask_q;
            new_row.scnt[0]  = COUNT_BITS'(1);
            wr_en            = 1'b1;
            set_valid        = 1'b1;
          end
        end else if (mfound) begin
          if (rd_q.scnt[midx] == '1) begin
            status = ST_SLOT_FULL;
          end else begin
            new_row.scnt[midx] = rd_q.scnt[midx] + COUNT_BITS'(1);
            new_row.dest       = rd_q.dest | mask_q;
            wr_en              = 1'b1;
          end
        end else if (!sfree) begin
          status = ST_SLOT_FULL;
        end else begin
          new_row.smask[sidx] = mask_q;
          new_row.scnt[sidx]  = COUNT_BITS'(1);
          new_row.dest        = rd_q.dest | mask_q;
          wr_en               = 1'b1;
        end
      end
      CMD_QUERY: drop = hit_q && rd_q.dest[mach_q];
      CMD_CLEAR: begin
        if (!hit_q) begin
          status = ST_NO_ENTRY;
        end else if (!mfound) begin
          status = ST_NO_MASK;
        end else begin
          new_row.scnt[midx] = cnt_dec;
          // last registration of this mask: drop bits nobody else covers
          if (cnt_dec == '0) new_row.dest = rd_q.dest & ~(mask_q & ~others);
          wr_en = 1'b1;
          if (new_row.dest == '0) clr_valid = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) row_mem[wr_idx] <= new_row;
    if (cmd_i.exec && set_valid) tag_q[wr_idx] <= addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.exec) begin
      if (set_valid) valid_q[wr_idx] <= 1'b1;
      if (clr_valid) valid_q[wr_idx] <= 1'b0;
    end
  end

  // result register
  logic             ovalid_q;
  logic             found_q, drop_q;
  logic [PortW-1:0] oport_q;
  logic [VcW-1:0]   ovc_q;
  logic [StatW-1:0] ostat_q;

  assign stat_o.out_free = !ovalid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      found_q <= hit_q;
      drop_q  <= drop;
      oport_q <= hit_q ? rd_q.port : '0;
      ovc_q   <= hit_q ? rd_q.vc : '0;
      ostat_q <= status;
    end
  end

  assign in_i.ready     = ready_i;
  assign out_o.valid    = ovalid_q;
  assign out_o.found    = found_q;
  assign out_o.drop     = drop_q;
  assign out_o.port_out = oport_q;
  assign out_o.vc_out   = ovc_q;
  assign out_o.status   = ostat_q;

  `ASSERT_CLK(a_one_hit, $onehot0(hit), "address matches more than one entry")
  `ASSERT_CLK(a_valid_only_exec, !cmd_i.exec |=> $stable(valid_q),
              "entry valid bits changed outside execute")
  `ASSERT_CLK(a_out_hold, (ovalid_q && !out_o.ready) |=> (ovalid_q && $stable(ostat_q)),
              "result item changed while waiting")

endmodule

`default_nettype wire

[rtl/multicast_prepush_filter_table.sv]
// Multicast prepush filter table: a request item (register, query or clear)
// is accepted when idle; its address is matched against all entries in the
// accept cycle while the entry row (mask, port, channel, mask slots) is read
// from memory, and the update and result are produced in the execute state,
// which waits while the result register is stalled; the next item is accepted
// only after that. One result item per request. No clearing pass after reset.
`default_nettype none

module multicast_prepush_filter_table
  import mpf_pkg::*;
#(
  parameter int unsigned ENTRIES    = DefEntries,
  parameter int unsigned MASK_SLOTS = DefMaskSlots,
  parameter int unsigned NODES      = DefNodes,
  parameter int unsigned COUNT_BITS = DefCountBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mpf_in_if.sink    in_i,
  mpf_out_if.source out_o
);

  mpf_cmd_t  cmd;
  mpf_stat_t stat;
  logic      in_ready;

  mpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mpf_dpath #(
    .ENTRIES    (ENTRIES),
    .MASK_SLOTS (MASK_SLOTS),
    .NODES      (NODES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .in_i   (in_i),
    .out_o  (out_o),
    .ready_i(in_ready)
  );

endmodule

`default_nettype wire
